@@ sv/decimal_ledger_sum_checker_assert.svh @@
// Assertion macros for the decimal ledger sum checker.
`ifndef DECIMAL_LEDGER_SUM_CHECKER_ASSERT_SVH
`define DECIMAL_LEDGER_SUM_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DLSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DLSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DLSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DLSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/dlsc_pkg.sv @@
// Shared types and constants of the decimal ledger sum checker.
`default_nettype none

package dlsc_pkg;

    localparam int MAX_ACCOUNTS = 256;
    localparam int CNT_W = $clog2(MAX_ACCOUNTS + 1);
    localparam int IDX_W = 8;
    localparam logic [31:0] MAX_ACC_32 = 32'(MAX_ACCOUNTS);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_SUPPLY = 3'b001,
        PH_COUNT  = 3'b010,
        PH_BAL    = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_NEGATIVE = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    typedef struct packed {
        t_phase             phase;
        logic               lead;
        logic               minus;
        logic [31:0]        acc;
        logic [31:0]        supply;
        logic [31:0]        count;
        logic [CNT_W-1:0]   done;
        logic [31:0]        total;
        logic               ovf;
        logic               neg;
        logic [IDX_W-1:0]   first;
        logic               halted;
    } t_ledger;

    localparam t_ledger LEDGER_RST = '{
        phase:  PH_SUPPLY,
        lead:   1'b1,
        minus:  1'b0,
        acc:    32'd0,
        supply: 32'd0,
        count:  32'd0,
        done:   '0,
        total:  32'd0,
        ovf:    1'b0,
        neg:    1'b0,
        first:  '0,
        halted: 1'b0
    };

endpackage

`default_nettype wire

@@ sv/dlsc_parse.sv @@
// Per-byte field parser holding the ledger state.
`default_nettype none

module dlsc_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_last,
    output dlsc_pkg::t_ledger     o_post
);
    import dlsc_pkg::*;

    t_ledger          r_st;
    t_ledger          n_st;
    logic             is_digit;
    logic             is_space;
    logic             is_minus;
    logic [31:0]      digit_val;
    logic [31:0]      bal;
    logic [31:0]      sum;
    logic [CNT_W-1:0] done_inc;
    logic             cnt_bad;

    always_comb begin
        is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_space  = (i_char == CH_SPACE);
        is_minus  = (i_char == CH_MINUS);
        digit_val = 32'(i_char - CH_ZERO);
        bal       = r_st.minus ? (32'd0 - r_st.acc) : r_st.acc;
        sum       = r_st.total + bal;
        done_inc  = r_st.done + CNT_W'(1);
        cnt_bad   = ($signed(r_st.acc) <= $signed(32'd0)) ||
                    ($signed(r_st.acc) > $signed(MAX_ACC_32));

        n_st = r_st;
        if (!r_st.halted) begin
            if (is_digit) begin
                n_st.acc  = (r_st.acc << 3) + (r_st.acc << 1) + digit_val;
                n_st.lead = 1'b0;
            end else if (r_st.lead) begin
                if (is_minus && (r_st.phase == PH_BAL)) begin
                    n_st.lead  = 1'b0;
                    n_st.minus = 1'b1;
                end else if (!is_space) begin
                    n_st.halted = 1'b1;
                end
            end else begin
                // close the field in progress
                n_st.acc   = 32'd0;
                n_st.lead  = 1'b1;
                n_st.minus = 1'b0;
                case (r_st.phase)
                    PH_SUPPLY: begin
                        n_st.supply = r_st.acc;
                        n_st.phase  = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_st.count = r_st.acc;
                        if (cnt_bad) begin
                            n_st.halted = 1'b1;
                        end else begin
                            n_st.phase = PH_BAL;
                            n_st.done  = '0;
                        end
                    end
                    PH_BAL: begin
                        if (bal[31] && !r_st.neg) begin
                            n_st.neg   = 1'b1;
                            n_st.first = IDX_W'(r_st.done);
                        end
                        n_st.total = sum;
                        if (sum[31]) begin
                            n_st.ovf = 1'b1;
                        end
                        n_st.done = done_inc;
                        if (done_inc >= r_st.count[CNT_W-1:0]) begin
                            n_st.halted = 1'b1;
                        end
                    end
                    default: begin
                        n_st.halted = 1'b1;
                    end
                endcase
                // offer the byte to the fresh field
                if (!n_st.halted) begin
                    if (is_minus && (n_st.phase == PH_BAL)) begin
                        n_st.lead  = 1'b0;
                        n_st.minus = 1'b1;
                    end else if (!is_space) begin
                        n_st.halted = 1'b1;
                    end
                end
            end
        end
    end

    assign o_post = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= LEDGER_RST;
        end else if (i_take) begin
            r_st <= i_last ? LEDGER_RST : n_st;
        end
    end

endmodule

`default_nettype wire

@@ sv/dlsc_report.sv @@
// Final field close and status selection for one finished ledger.
`default_nettype none

module dlsc_report (
    input  wire dlsc_pkg::t_ledger   i_snap,
    output dlsc_pkg::t_status        o_status,
    output logic [7:0]               o_bad_account,
    output logic [31:0]              o_expected_total,
    output logic [31:0]              o_actual_total,
    output logic [31:0]              o_account_count
);
    import dlsc_pkg::*;

    t_ledger     fin;
    logic [31:0] bal;
    logic [31:0] sum;

    always_comb begin
        bal = i_snap.minus ? (32'd0 - i_snap.acc) : i_snap.acc;
        sum = i_snap.total + bal;

        fin = i_snap;
        if (!i_snap.halted) begin
            case (i_snap.phase)
                PH_SUPPLY: begin
                    fin.supply = i_snap.acc;
                end
                PH_COUNT: begin
                    fin.count = i_snap.acc;
                end
                PH_BAL: begin
                    if (bal[31] && !i_snap.neg) begin
                        fin.neg   = 1'b1;
                        fin.first = IDX_W'(i_snap.done);
                    end
                    fin.total = sum;
                    if (sum[31]) begin
                        fin.ovf = 1'b1;
                    end
                end
                default: begin
                    fin = i_snap;
                end
            endcase
        end

        o_bad_account = 8'd0;
        if ($signed(fin.count) > $signed(MAX_ACC_32)) begin
            o_status = ST_TOO_MANY;
        end else if (fin.neg) begin
            o_status      = ST_NEGATIVE;
            o_bad_account = 8'(fin.first);
        end else if (fin.ovf) begin
            o_status = ST_OVERFLOW;
        end else if (fin.total != fin.supply) begin
            o_status = ST_MISMATCH;
        end else begin
            o_status = ST_VALID;
        end

        o_expected_total = fin.supply;
        o_actual_total   = fin.total;
        o_account_count  = fin.count;
    end

endmodule

`default_nettype wire

@@ sv/decimal_ledger_sum_checker.sv @@
// A finished ledger goes to the snapshot register, then its result to the output register.
// One byte per cycle unless stalled; the parser register closes at most one field per byte.
// A result that waits on m_axis_tready sits in the output register and the snapshot
// register takes one more finished ledger; input stalls while both are full and tready is low.
// Reset: synchronous, active low; clears parser state and both valid flags.
`default_nettype none
`include "decimal_ledger_sum_checker_assert.svh"

module decimal_ledger_sum_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] char_in
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [103:0]       m_axis_tdata,   // bad_account, expected_total, actual_total,
                                               // account_count
    output logic [2:0]         m_axis_tuser    // status
);
    import dlsc_pkg::*;

    t_ledger     post;
    t_ledger     r_snap;
    logic        r_snap_valid;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [7:0]  r_out_bad;
    logic [31:0] r_out_expected;
    logic [31:0] r_out_actual;
    logic [31:0] r_out_count;
    t_status     rep_status;
    logic [7:0]  rep_bad;
    logic [31:0] rep_expected;
    logic [31:0] rep_actual;
    logic [31:0] rep_count;
    logic        take;
    logic        snap_move;

    assign snap_move     = r_snap_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_snap_valid || !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    dlsc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_post  (post)
    );

    dlsc_report u_report (
        .i_snap           (r_snap),
        .o_status         (rep_status),
        .o_bad_account    (rep_bad),
        .o_expected_total (rep_expected),
        .o_actual_total   (rep_actual),
        .o_account_count  (rep_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (take && s_axis_tlast) begin
            r_snap_valid <= 1'b1;
        end else if (snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && s_axis_tlast) begin
            r_snap <= post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_out_status   <= rep_status;
            r_out_bad      <= rep_bad;
            r_out_expected <= rep_expected;
            r_out_actual   <= rep_actual;
            r_out_count    <= rep_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_count, r_out_actual, r_out_expected, r_out_bad};

    `DLSC_ASSERT_NXT(a_snap_hold, i_clk, i_rst_n, r_snap_valid && !snap_move, r_snap_valid)
    `DLSC_ASSERT_NXT(a_last_snap, i_clk, i_rst_n, take && s_axis_tlast, r_snap_valid)
    `DLSC_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !r_snap_valid, s_axis_tready)
    `DLSC_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_NEGATIVE), r_out_bad == 8'd0)

endmodule

`default_nettype wire

@@ sim/decimal_ledger_sum_checker_checker.sv @@
// Ledger checker: predicts the verdict of each text from the input transfers and compares results.
`timescale 1ns / 1ps

module decimal_ledger_sum_checker_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_in
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // [7:0] bad_account, [39:8] expected_total,
                                         // [71:40] actual_total, [103:72] account_count
    input  logic [2:0]   m_axis_tuser,   // [2:0] status
    output int           o_fail_count,
    output int           o_pending
);
    import dlsc_pkg::*;

    typedef struct {
        t_phase      phase;
        bit          lead;
        bit          minus;
        bit [31:0]   acc;
        bit [31:0]   supply;
        bit [31:0]   count;
        int          done;
        bit [31:0]   total;
        bit          ovf;
        bit          neg;
        bit [7:0]    first;
        bit          halted;
    } t_parser;

    typedef struct {
        t_status     status;
        bit [7:0]    bad;
        bit [31:0]   supply;
        bit [31:0]   total;
        bit [31:0]   count;
    } t_verdict;

    t_parser  ledger;
    t_verdict verdict_q[$];

    function automatic void clear_ledger();
        ledger.phase  = PH_SUPPLY;
        ledger.lead   = 1'b1;
        ledger.minus  = 1'b0;
        ledger.acc    = '0;
        ledger.supply = '0;
        ledger.count  = '0;
        ledger.done   = 0;
        ledger.total  = '0;
        ledger.ovf    = 1'b0;
        ledger.neg    = 1'b0;
        ledger.first  = '0;
        ledger.halted = 1'b0;
    endfunction

    function automatic void close_ledger_field();
        bit [31:0] v;
        v = ledger.acc;
        case (ledger.phase)
            PH_SUPPLY: begin
                ledger.supply = v;
                ledger.phase  = PH_COUNT;
            end
            PH_COUNT: begin
                ledger.count = v;
                if ($signed(v) <= 0 || $signed(v) > MAX_ACCOUNTS) begin
                    ledger.halted = 1'b1;
                end else begin
                    ledger.phase = PH_BAL;
                    ledger.done  = 0;
                end
            end
            default: begin
                if (ledger.minus) v = -v;
                if (v[31] && !ledger.neg) begin
                    ledger.neg   = 1'b1;
                    ledger.first = 8'(ledger.done);
                end
                ledger.total = ledger.total + v;
                if (ledger.total[31]) ledger.ovf = 1'b1;
                ledger.done++;
                if (ledger.done >= $signed(ledger.count)) ledger.halted = 1'b1;
            end
        endcase
        ledger.acc   = '0;
        ledger.lead  = 1'b1;
        ledger.minus = 1'b0;
    endfunction

    function automatic void take_ledger_byte(bit [7:0] c);
        bit fresh;
        for (int pass = 0; pass < 2 && !ledger.halted; pass++) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                ledger.acc  = ledger.acc * 32'd10 + 32'(c - CH_ZERO);
                ledger.lead = 1'b0;
                return;
            end
            if (ledger.lead && c == CH_SPACE) return;
            if (ledger.lead && c == CH_MINUS && ledger.phase == PH_BAL) begin
                ledger.lead  = 1'b0;
                ledger.minus = 1'b1;
                return;
            end
            fresh = ledger.lead;
            close_ledger_field();
            if (fresh) ledger.halted = 1'b1;
        end
    endfunction

    function automatic void absorb_ledger_byte(bit [7:0] c, bit last);
        t_verdict v;
        take_ledger_byte(c);
        if (!last) return;
        if (!ledger.halted) begin
            close_ledger_field();
            ledger.halted = 1'b1;
        end
        v.bad = '0;
        if ($signed(ledger.count) > MAX_ACCOUNTS) begin
            v.status = ST_TOO_MANY;
        end else if (ledger.neg) begin
            v.status = ST_NEGATIVE;
            v.bad    = ledger.first;
        end else if (ledger.ovf) begin
            v.status = ST_OVERFLOW;
        end else if (ledger.total != ledger.supply) begin
            v.status = ST_MISMATCH;
        end else begin
            v.status = ST_VALID;
        end
        v.supply = ledger.supply;
        v.total  = ledger.total;
        v.count  = ledger.count;
        verdict_q.push_back(v);
        clear_ledger();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("result with no ledger pending, status %0d",
                                      m_axis_tuser));
            return;
        end
        want = verdict_q.pop_front();
        if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[7:0] !== want.bad)
            report_mismatch($sformatf("bad_account got %0d want %0d",
                                      m_axis_tdata[7:0], want.bad));
        if (m_axis_tdata[39:8] !== want.supply)
            report_mismatch($sformatf("expected_total got %h want %h",
                                      m_axis_tdata[39:8], want.supply));
        if (m_axis_tdata[71:40] !== want.total)
            report_mismatch($sformatf("actual_total got %h want %h",
                                      m_axis_tdata[71:40], want.total));
        if (m_axis_tdata[103:72] !== want.count)
            report_mismatch($sformatf("account_count got %h want %h",
                                      m_axis_tdata[103:72], want.count));
    endtask

    initial clear_ledger();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_ledger();
            verdict_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_verdict();
            if (s_axis_tvalid && s_axis_tready) absorb_ledger_byte(s_axis_tdata, s_axis_tlast);
        end
        o_pending <= verdict_q.size();
    end

endmodule

@@ sim/decimal_ledger_sum_checker_tb.sv @@
// Testbench top: drives ledger texts into the sum checker and reports the verdict.
`timescale 1ns / 1ps

module decimal_ledger_sum_checker_tb;
    import dlsc_pkg::*;

    localparam int ITEM_TARGET  = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [7:0] t_text[$];

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata  = 8'h00;   // [7:0] char_in
    logic           s_axis_tlast  = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [103:0]   m_axis_tdata;            // [7:0] bad_account, [39:8] expected_total,
                                             // [71:40] actual_total, [103:72] account_count
    logic [2:0]     m_axis_tuser;            // [2:0] status

    int fail_count;
    int pending;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    decimal_ledger_sum_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    decimal_ledger_sum_checker_checker u_ledger_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern: switch among four ready modes at random
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_left[3:0] == 4'd0);
        endcase
    end

    function automatic void add_str(ref t_text t, input string s);
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    endfunction

    function automatic void add_spaces(ref t_text t, input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) t.push_back(CH_SPACE);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_MINUS);
        return c;
    endfunction

    function automatic t_text random_ledger();
        t_text      t;
        t_text      bal_t;
        int         r;
        int         nbal;
        int         bk;
        bit         neg;
        bit         dash_only;
        bit         tiny;
        bit [31:0]  n;
        bit [31:0]  mag;
        bit [31:0]  sum;
        bit [31:0]  supply;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
            return t;
        end
        r = $urandom_range(0, 99);
        tiny = 1'b0;
        if (r < 70)      n = $urandom_range(1, 5);
        else if (r < 80) n = $urandom_range(6, 24);
        else if (r < 85) n = 0;
        else if (r < 91) n = $urandom_range(257, 3000);
        else if (r < 95) n = $urandom;
        else if (r < 97) begin
            n = $urandom_range(200, 256);
            tiny = 1'b1;
        end else begin
            n = 1;
        end
        if ($signed(n) >= 1 && $signed(n) <= MAX_ACCOUNTS) begin
            nbal = int'(n);
            if ($urandom_range(0, 9) == 0) nbal = nbal - $urandom_range(1, nbal);
            else if ($urandom_range(0, 9) == 0) nbal = nbal + $urandom_range(1, 2);
        end else begin
            nbal = $urandom_range(0, 3);
        end
        sum = '0;
        for (int i = 0; i < nbal; i++) begin
            if ($urandom_range(0, 19) == 0) bal_t.push_back(junk_char());
            else add_spaces(bal_t, 1, 2);
            bk = tiny ? 0 : $urandom_range(0, 99);
            neg = 1'b0;
            dash_only = 1'b0;
            if (tiny)          mag = $urandom_range(0, 9);
            else if (bk < 60)  mag = $urandom_range(0, 999);
            else if (bk < 72) begin
                mag = $urandom_range(1, 999);
                neg = 1'b1;
            end else if (bk < 82) begin
                mag = $urandom;
                neg = 1'($urandom_range(0, 1));
            end else if (bk < 86) begin
                mag = 0;
                neg = 1'b1;
                dash_only = 1'b1;
            end else if (bk < 92) begin
                mag = $urandom_range(0, 99);
                add_str(bal_t, "00");
            end else begin
                mag = 0;
            end
            if (neg) bal_t.push_back(CH_MINUS);
            if (!dash_only) add_str(bal_t, $sformatf("%0d", mag));
            sum = neg ? sum - mag : sum + mag;
        end
        r = $urandom_range(0, 99);
        if (r < 45)      supply = sum;
        else if (r < 90) supply = $urandom_range(0, 5000);
        else             supply = $urandom;
        add_spaces(t, 0, 2);
        add_str(t, $sformatf("%0d", supply));
        add_spaces(t, 1, 2);
        add_str(t, $sformatf("%0d", n));
        t = {t, bal_t};
        if ($urandom_range(0, 9) == 0) begin
            t.push_back(CH_SPACE);
            repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(0, 255)));
        end
        return t;
    endfunction

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tlast  <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic push_byte(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input t_text t, input bit gappy);
        for (int i = 0; i < t.size(); i++) begin
            push_byte(t[i], i == t.size() - 1);
            if (gappy) begin
                if (burst_left == 0) begin
                    idle_for($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
    endtask

    initial begin
        t_text t;
        string directed[$];
        directed = '{"10 2 4 6", "5 3 1 -2 6", "0 2 2000000000 2000000000", "7 2 3 3", "9",
                     "0 0 5", "3 2 - 3", "0 1 4294967295", "1 1 1 junk", "4 x", "  2 1 2",
                     "0 -3", "0 257 1"};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) begin
            t.delete();
            add_str(t, directed[i]);
            send_text(t, 1'b1);
        end
        send_text('{8'h00}, 1'b0);
        send_text('{8'hFF, 8'h31}, 1'b0);
        while (bytes_sent < ITEM_TARGET) send_text(random_ledger(), $urandom_range(0, 3) != 0);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dlsc_pkg.sv
sv/dlsc_parse.sv
sv/dlsc_report.sv
sv/decimal_ledger_sum_checker.sv
sim/decimal_ledger_sum_checker_checker.sv
sim/decimal_ledger_sum_checker_tb.sv
